// ----- design/kdsf_pkg.sv -----
// ----------------------------------------------------------------------------
// kdsf_pkg
// Shared types and codes for the k-mer dictionary with singleton filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kdsf_pkg;

   localparam int COL_BITS = 16;
   localparam int NUM_BITS = 17;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MISS      = 2'd1,
      ST_FULL      = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      FN_REGISTER = 1'b0,
      FN_LOOKUP   = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EVAL
   } back_state_type;

   typedef struct packed {
      logic                valid;
      status_type          status;
      logic                found;
      logic                added;
      logic [COL_BITS-1:0] column_index;
   } rsp_type;

endpackage

`default_nettype wire

// ----- design/kdsf_queue.sv -----
// ----------------------------------------------------------------------------
// kdsf_queue
// Two-entry queue between the classifying front and the store back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kdsf_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      head
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- design/kdsf_front.sv -----
// ----------------------------------------------------------------------------
// kdsf_front
// Accepts items, masks the key and computes its bucket (fold, then modulo).
// ----------------------------------------------------------------------------
`default_nettype none

module kdsf_front import kdsf_pkg::*; #(
   parameter int BUCKETS  = 16384,
   parameter int KEY_BITS = 64,
   parameter int BW       = 14
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      hold,
   output logic                           busy,
   input  wire logic                      req_func,
   input  wire logic [63:0]               req_kmer,
   input  wire logic                      q_full,
   output logic                           q_push,
   output logic [KEY_BITS+BW:0]           q_data
);

   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / BUCKETS);

   logic                s1_v_ff, s1_v_in;
   logic                s1_func_ff;
   logic [KEY_BITS-1:0] s1_key_ff;
   logic                s2_v_ff, s2_v_in;
   logic                s2_func_ff;
   logic [KEY_BITS-1:0] s2_key_ff;
   logic [15:0]         s2_fold_ff;
   logic [15:0]         s2_quot_ff;

   logic        accept, s1_adv, s2_adv;
   logic [63:0] key_wide;
   logic [15:0] fold;
   logic [48:0] prod;
   logic [32:0] rem_raw, rem;

   assign s2_adv = s2_v_ff & ~q_full;
   assign s1_adv = s1_v_ff & (~s2_v_ff | s2_adv);
   assign busy   = hold | (s1_v_ff & ~s1_adv);
   assign accept = start & ~busy;

   always_comb begin
      key_wide = 64'(s1_key_ff);
      fold     = key_wide[15:0] ^ key_wide[31:16] ^ key_wide[47:32] ^ key_wide[63:48];
      prod     = 49'(fold) * 49'(RECIP);
      // quotient may be one short: one compare and subtract corrects it
      rem_raw  = 33'(s2_fold_ff) - 33'(33'(s2_quot_ff) * 33'(BUCKETS));
      rem      = (rem_raw >= 33'(BUCKETS)) ? rem_raw - 33'(BUCKETS) : rem_raw;
      s1_v_in  = accept | (s1_v_ff & ~s1_adv);
      s2_v_in  = s1_adv | (s2_v_ff & ~s2_adv);
   end

   assign q_push = s2_adv;
   assign q_data = {s2_func_ff, s2_key_ff, rem[BW-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff <= req_func;
         s1_key_ff  <= req_kmer[KEY_BITS-1:0];
      end
      if (s1_adv) begin
         s2_func_ff <= s1_func_ff;
         s2_key_ff  <= s1_key_ff;
         s2_fold_ff <= fold;
         s2_quot_ff <= prod[47:32];
      end
   end

endmodule

`default_nettype wire

// ----- design/kdsf_back.sv -----
// ----------------------------------------------------------------------------
// kdsf_back
// Bucket stores: reads a row, decides hit, insert or promotion, writes back.
// ----------------------------------------------------------------------------
`default_nettype none

module kdsf_back import kdsf_pkg::*; #(
   parameter int BUCKETS  = 16384,
   parameter int WAYS     = 4,
   parameter int KEY_BITS = 64,
   parameter int BW       = 14
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 filter_singletons,
   input  wire logic                 q_empty,
   input  wire logic [KEY_BITS+BW:0] q_head,
   output logic                      q_pop,
   output logic                      clearing,
   output rsp_type                   rsp
);

   localparam int DW = KEY_BITS + COL_BITS + 1;
   localparam int OW = KEY_BITS + 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic [WAYS-1:0][DW-1:0] dmem [BUCKETS];
   logic [WAYS-1:0][OW-1:0] omem [BUCKETS];
   logic [WAYS-1:0][DW-1:0] drow_ff, drow_new;
   logic [WAYS-1:0][OW-1:0] orow_ff, orow_new;

   back_state_type state_ff, state_in;
   logic [BW-1:0]       clr_ff, clr_in;
   logic [NUM_BITS-1:0] next_ff, next_in;
   logic                func_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [BW-1:0]       bkt_ff;
   rsp_type             rsp_ff, rsp_in;

   logic                d_we, o_we;
   logic [BW-1:0]       waddr;
   logic [WAYS-1:0]     dhit, ohit;
   logic                dhit_any, ohit_any, dfree_any, ofree_any;
   logic [WW-1:0]       dhit_w, ohit_w, dfree_w, ofree_w;
   logic                ev_d_we, ev_o_we, ev_add;
   status_type          ev_status;
   logic                ev_found;
   logic [COL_BITS-1:0] ev_col;
   logic                number_it;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: if (clr_ff == BW'(BUCKETS - 1)) begin
            state_in = BK_IDLE;
         end
         BK_IDLE:  if (!q_empty) begin
            state_in = BK_EVAL;
         end
         BK_EVAL:  state_in = BK_IDLE;
         default:  state_in = BK_CLEAR;
      endcase
   end

   // way search over the registered rows
   always_comb begin
      dhit = '0; ohit = '0;
      dhit_w = '0; ohit_w = '0; dfree_w = '0; ofree_w = '0;
      dfree_any = 1'b0; ofree_any = 1'b0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         dhit[w] = drow_ff[w][DW-1] & (drow_ff[w][DW-2:COL_BITS] == key_ff);
         ohit[w] = orow_ff[w][OW-1] & (orow_ff[w][OW-2:0] == key_ff);
         if (dhit[w]) dhit_w = WW'(w);
         if (ohit[w]) ohit_w = WW'(w);
         if (!drow_ff[w][DW-1]) begin
            dfree_w = WW'(w);
            dfree_any = 1'b1;
         end
         if (!orow_ff[w][OW-1]) begin
            ofree_w = WW'(w);
            ofree_any = 1'b1;
         end
      end
      dhit_any = |dhit;
      ohit_any = |ohit;
   end

   // classify the item and build the write-back rows
   always_comb begin
      ev_status = ST_OK;
      ev_found  = 1'b0;
      ev_add    = 1'b0;
      ev_col    = '0;
      ev_d_we   = 1'b0;
      ev_o_we   = 1'b0;
      number_it = 1'b1;
      drow_new  = drow_ff;
      orow_new  = orow_ff;
      if (dhit_any) begin
         ev_found = 1'b1;
         ev_col   = drow_ff[dhit_w][COL_BITS-1:0];
      end else if (func_ff == FN_LOOKUP) begin
         ev_status = ST_MISS;
      end else begin
         if (filter_singletons && !ohit_any) begin
            number_it = 1'b0;
            if (!ofree_any) begin
               ev_status = ST_FULL;
            end else begin
               orow_new[ofree_w] = {1'b1, key_ff};
               ev_o_we = 1'b1;
            end
         end
         if (number_it) begin
            if (next_ff[NUM_BITS-1]) begin
               ev_status = ST_EXHAUSTED;
            end else if (!dfree_any) begin
               ev_status = ST_FULL;
            end else begin
               drow_new[dfree_w] = {1'b1, key_ff, next_ff[COL_BITS-1:0]};
               ev_d_we  = 1'b1;
               ev_found = 1'b1;
               ev_add   = 1'b1;
               ev_col   = next_ff[COL_BITS-1:0];
               // promotion: drop the seen-once entry
               if (filter_singletons && ohit_any) begin
                  orow_new[ohit_w] = '0;
                  ev_o_we = 1'b1;
               end
            end
         end
      end
   end

   // outputs of the sequencer
   always_comb begin
      q_pop    = 1'b0;
      clearing = 1'b0;
      d_we     = 1'b0;
      o_we     = 1'b0;
      waddr    = bkt_ff;
      clr_in   = clr_ff;
      next_in  = next_ff;
      rsp_in   = '0;
      case (state_ff)
         BK_CLEAR: begin
            clearing = 1'b1;
            d_we     = 1'b1;
            o_we     = 1'b1;
            waddr    = clr_ff;
            clr_in   = clr_ff + BW'(1);
         end
         BK_IDLE:  q_pop = ~q_empty;
         BK_EVAL: begin
            d_we   = ev_d_we;
            o_we   = ev_o_we;
            rsp_in = '{valid: 1'b1, status: ev_status, found: ev_found,
                       added: ev_add, column_index: ev_col};
            if (ev_add) begin
               next_in = next_ff + NUM_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff   <= '0;
         next_ff  <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         next_ff  <= next_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         func_ff <= q_head[KEY_BITS+BW];
         key_ff  <= q_head[KEY_BITS+BW-1:BW];
         bkt_ff  <= q_head[BW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         dmem[waddr] <= clearing ? '0 : drow_new;
      end
      drow_ff <= dmem[q_head[BW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (o_we) begin
         omem[waddr] <= clearing ? '0 : orow_new;
      end
      orow_ff <= omem[q_head[BW-1:0]];
   end

   a_rsp_after_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.valid |-> $past(state_ff == BK_EVAL))
      else $error("response without an evaluated item");

   a_number_bound: assert property (@(posedge clock) disable iff (reset)
      !(next_ff[NUM_BITS-1] && (next_ff[NUM_BITS-2:0] != '0)))
      else $error("column numbering past its limit");

   a_added_found: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.added |-> rsp_ff.found && (rsp_ff.status == ST_OK))
      else $error("added item not reported as found");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_EVAL |-> $onehot0(dhit))
      else $error("key held in two ways of one bucket");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop)
      else $error("item taken during clearing pass");

endmodule

`default_nettype wire

// ----- design/kmer_dictionary_singleton_filter.sv -----
// Path to rsp: front s1 and s2 registers, the queue, the row read, the rsp register.
// The back end reads a bucket row and writes it back before it takes the next item.
// The front takes a new item each cycle while the queue has room; busy marks a stall.
// Reset: synchronous; then a clearing pass over all BUCKETS rows holds busy high.
// Results are shown for one cycle on rsp_valid; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// kmer_dictionary_singleton_filter
// Assigns dense column numbers to k-mers, with an optional seen-once filter.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_dictionary_singleton_filter import kdsf_pkg::*; #(
   parameter int BUCKETS  = 16384,
   parameter int WAYS     = 4,
   parameter int KEY_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_wdata,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [63:0] req_kmer,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic             rsp_found,
   output logic             rsp_added,
   output logic [15:0]      rsp_column_index
);

   localparam int BW = $clog2(BUCKETS);
   localparam int QW = KEY_BITS + BW + 1;

   logic          filter_ff;
   logic          q_push, q_full, q_pop, q_empty, clearing;
   logic [QW-1:0] q_data, q_head;
   rsp_type       rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= 1'b0;
      end else if (csr_we) begin
         filter_ff <= csr_wdata;
      end
   end

   kdsf_front #(.BUCKETS(BUCKETS), .KEY_BITS(KEY_BITS), .BW(BW)) u_front (
      .clock, .reset, .start, .hold(clearing), .busy, .req_func, .req_kmer,
      .q_full, .q_push, .q_data
   );

   kdsf_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .push(q_push), .push_data(q_data), .full(q_full),
      .pop(q_pop), .empty(q_empty), .head(q_head)
   );

   kdsf_back #(.BUCKETS(BUCKETS), .WAYS(WAYS), .KEY_BITS(KEY_BITS), .BW(BW)) u_back (
      .clock, .reset, .filter_singletons(filter_ff), .q_empty, .q_head, .q_pop,
      .clearing, .rsp
   );

   assign rsp_valid        = rsp.valid;
   assign rsp_status       = rsp.status;
   assign rsp_found        = rsp.found;
   assign rsp_added        = rsp.added;
   assign rsp_column_index = rsp.column_index;

endmodule

`default_nettype wire
